FILE: design/tpu_pkg.sv
// Shared types and constants for the tracker pattern unpacker.
package tpu_pkg;

	typedef enum logic [2:0] {
		EV_NOTE_ON  = 3'd0,
		EV_NOTE_OFF = 3'd1,
		EV_VOLUME   = 3'd2,
		EV_SPEED    = 3'd3,
		EV_TEMPO    = 3'd4
	} ev_kind_t;

	typedef enum logic [5:0] {
		PH_FLAG = 6'b000001,
		PH_NOTE = 6'b000010,
		PH_INST = 6'b000100,
		PH_VOL  = 6'b001000,
		PH_CMD  = 6'b010000,
		PH_INFO = 6'b100000
	} phase_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [3:0]  channel;
		logic [5:0]  row_delay;
		logic [7:0]  instrument;
		logic [7:0]  note;
		logic [9:0]  level;
		logic        use_default_level;
		logic [7:0]  tempo_value;
		logic        last;
	} event_t;

	localparam logic [7:0] FLAG_NOTE   = 8'h80;
	localparam logic [7:0] FLAG_INST   = 8'h40;
	localparam logic [7:0] FLAG_VOL    = 8'h20;
	localparam logic [7:0] FLAG_CMD    = 8'h10;
	localparam logic [7:0] CMD_VOLUME  = 8'h0c;
	localparam logic [7:0] CMD_TEMPO   = 8'h0f;
	localparam logic [7:0] NOTE_OFF    = 8'd254;
	localparam logic [7:0] NOTE_NONE   = 8'd255;
	localparam logic [7:0] VOL_FULL    = 8'd64;
	localparam logic [7:0] VOL_NONE    = 8'd255;
	localparam logic [7:0] SPEED_LIMIT = 8'd32;
	localparam logic [9:0] LEVEL_FULL  = 10'd255;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	function automatic logic [9:0] scale_level(input logic [7:0] v);
		if (v == VOL_FULL) begin
			return LEVEL_FULL;
		end
		return {v, 2'b00} | {6'd0, v[7:4]};
	endfunction

	// next phase: first optional byte at or after the given phase
	function automatic phase_t phase_after(input logic [7:0] f, input phase_t from);
		logic ge_note;
		logic ge_inst;
		logic ge_vol;
		ge_note = (from == PH_NOTE);
		ge_inst = ge_note || (from == PH_INST);
		ge_vol  = ge_inst || (from == PH_VOL);
		if (ge_note && f[7]) begin
			return PH_NOTE;
		end else if (ge_inst && f[6]) begin
			return PH_INST;
		end else if (ge_vol && f[5]) begin
			return PH_VOL;
		end else if (f[4]) begin
			return PH_CMD;
		end
		return PH_FLAG;
	endfunction

endpackage

FILE: design/tracker_pattern_unpacker_top.sv
// Tracker pattern unpacker: packed pattern words in, note and effect events out.
//
// Input channel: data_byte and pattern_start, one word per accepted handshake
// (in_valid/in_ready). pattern_start on a word restarts the row count, clears
// the per-channel row and instrument tables and takes the word as a flag byte.
// Output channel: one event per handshake (out_valid/out_ready); last marks
// the final event caused by one input word.
// Each input word is parsed in the cycle it is accepted; its zero, one or two
// events are registered in a four-entry event queue, whose head is offered on
// the output. Throughput is one input word per cycle while in_ready is high;
// a word that yields two events takes two output handshakes.
// in_ready is low while three or more events are queued, so a stalled receiver
// stops the input once the queue holds three or four events.
// Reset clears the parser, row count, channel tables and the event queue.
module tracker_pattern_unpacker_top #(
	parameter int CHANNELS = 16,
	parameter int ROWS     = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 pattern_start,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tpu_pkg::ev_kind_t    event_kind,
	output logic [3:0]           channel,
	output logic [5:0]           row_delay,
	output logic [7:0]           instrument,
	output logic [7:0]           note,
	output logic [9:0]           level,
	output logic                 use_default_level,
	output logic [7:0]           tempo_value,
	output logic                 last
);
	import tpu_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	phase_t       phase_q;
	logic [7:0]   flags_q;
	logic [7:0]   note_q;
	logic [7:0]   inst_q;
	logic [7:0]   vol_q;
	logic [7:0]   cmd_q;
	logic [6:0]   row_q;
	logic [5:0]   last_row_q [CHANNELS];
	logic [7:0]   last_inst_q [CHANNELS];

	event_t              evq_q [QDEPTH];
	logic [QPTR_W-1:0]   head_q;
	logic [QCNT_W-1:0]   cnt_q;

	logic         accept;
	logic         active;
	phase_t       ph_eff;
	phase_t       ph_n;
	logic [6:0]   row_eff;
	logic [7:0]   flags_n;
	logic [7:0]   note_n;
	logic [7:0]   inst_n;
	logic [7:0]   vol_n;
	logic [7:0]   cmd_n;
	logic [7:0]   info;
	logic         fin;
	logic         ch_ok;
	logic [CH_W-1:0] idx;
	logic [5:0]   last_row_rd;
	logic [7:0]   last_inst_rd;
	logic [5:0]   delay0;
	logic         e0v;
	logic         e1v;
	logic         inst_wr;
	logic [7:0]   inst_ev;
	event_t       e0;
	event_t       e1;
	logic         pop;
	logic [1:0]   push_n;
	logic [QPTR_W-1:0] tail;

	assign accept  = in_valid && in_ready;
	assign row_eff = pattern_start ? 7'd0 : row_q;
	assign ph_eff  = pattern_start ? PH_FLAG : phase_q;
	assign active  = accept && (row_eff < 7'(ROWS));

	always_comb begin
		flags_n = flags_q;
		note_n  = note_q;
		inst_n  = inst_q;
		vol_n   = vol_q;
		cmd_n   = cmd_q;
		info    = 8'd0;
		fin     = 1'b0;
		ph_n    = PH_FLAG;
		unique case (ph_eff)
			PH_FLAG: begin
				flags_n = data_byte;
				note_n  = 8'd0;
				inst_n  = 8'd0;
				vol_n   = VOL_NONE;
				cmd_n   = 8'd0;
				ph_n    = phase_after(data_byte, PH_NOTE);
				fin     = (ph_n == PH_FLAG);
			end
			PH_NOTE: begin
				note_n = data_byte;
				ph_n   = phase_after(flags_q, PH_INST);
				fin    = (ph_n == PH_FLAG);
			end
			PH_INST: begin
				inst_n = data_byte;
				ph_n   = phase_after(flags_q, PH_VOL);
				fin    = (ph_n == PH_FLAG);
			end
			PH_VOL: begin
				vol_n = data_byte;
				ph_n  = phase_after(flags_q, PH_CMD);
				fin   = (ph_n == PH_FLAG);
			end
			PH_CMD: begin
				cmd_n = data_byte;
				ph_n  = PH_INFO;
			end
			PH_INFO: begin
				info = data_byte;
				fin  = 1'b1;
				ph_n = PH_FLAG;
			end
			default: begin
				ph_n = PH_FLAG;
			end
		endcase
	end

	// event build on the final word of an entry
	always_comb begin
		ch_ok        = fin && (flags_n != 8'd0) && ({1'b0, flags_n[3:0]} < 5'(CHANNELS));
		idx          = flags_n[CH_W-1:0];
		last_row_rd  = pattern_start ? 6'd0 : last_row_q[idx];
		last_inst_rd = pattern_start ? 8'd0 : last_inst_q[idx];
		delay0       = row_eff[5:0] - last_row_rd;

		inst_wr = 1'b0;
		inst_ev = last_inst_rd;
		e0      = '0;
		e1      = '0;
		e0v     = 1'b0;
		e1v     = 1'b0;

		e0.channel   = flags_n[3:0];
		e0.row_delay = delay0;
		if ((flags_n & FLAG_NOTE) != 8'd0) begin
			if (note_n == NOTE_OFF) begin
				e0v     = 1'b1;
				e0.kind = EV_NOTE_OFF;
				e0.note = NOTE_OFF;
			end else if (note_n != NOTE_NONE) begin
				e0v = 1'b1;
				if (inst_n != 8'd0) begin
					inst_wr = 1'b1;
					inst_ev = inst_n - 8'd1;
				end
				e0.kind       = EV_NOTE_ON;
				e0.note       = note_n;
				e0.instrument = inst_ev;
				if (((flags_n & FLAG_VOL) != 8'd0) && (vol_n <= VOL_FULL)) begin
					e0.level = scale_level(vol_n);
				end else begin
					e0.use_default_level = 1'b1;
				end
			end
		end else if ((flags_n & FLAG_VOL) != 8'd0) begin
			e0v      = 1'b1;
			e0.kind  = EV_VOLUME;
			e0.level = scale_level(vol_n);
		end

		e1.channel   = flags_n[3:0];
		e1.row_delay = e0v ? 6'd0 : delay0;
		if ((flags_n & FLAG_CMD) != 8'd0) begin
			if (cmd_n == CMD_VOLUME) begin
				e1v      = 1'b1;
				e1.kind  = EV_VOLUME;
				e1.level = (info >= VOL_FULL) ? LEVEL_FULL : scale_level(info);
			end else if ((cmd_n == CMD_TEMPO) && (info != 8'd0)) begin
				e1v            = 1'b1;
				e1.kind        = (info < SPEED_LIMIT) ? EV_SPEED : EV_TEMPO;
				e1.tempo_value = info;
			end
		end

		if (!ch_ok) begin
			e0v     = 1'b0;
			e1v     = 1'b0;
			inst_wr = 1'b0;
		end
		e1.last = 1'b1;
		e0.last = !e1v;
	end

	assign pop    = out_valid && out_ready;
	assign push_n = active ? ({1'b0, e0v} + {1'b0, e1v}) : 2'd0;
	assign tail   = head_q + cnt_q[QPTR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			flags_q <= 8'd0;
			note_q  <= 8'd0;
			inst_q  <= 8'd0;
			vol_q   <= VOL_NONE;
			cmd_q   <= 8'd0;
			row_q   <= 7'd0;
			for (int i = 0; i < CHANNELS; i++) begin
				last_row_q[i]  <= 6'd0;
				last_inst_q[i] <= 8'd0;
			end
		end else if (active) begin
			phase_q <= ph_n;
			flags_q <= flags_n;
			note_q  <= note_n;
			inst_q  <= inst_n;
			vol_q   <= vol_n;
			cmd_q   <= cmd_n;
			row_q   <= (fin && (flags_n == 8'd0)) ? row_eff + 7'd1 : row_eff;
			for (int i = 0; i < CHANNELS; i++) begin
				if ((e0v || e1v) && (idx == CH_W'(i))) begin
					last_row_q[i] <= row_eff[5:0];
				end else if (pattern_start) begin
					last_row_q[i] <= 6'd0;
				end
				if (inst_wr && (idx == CH_W'(i))) begin
					last_inst_q[i] <= inst_ev;
				end else if (pattern_start) begin
					last_inst_q[i] <= 8'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q - QCNT_W'(pop) + QCNT_W'(push_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QDEPTH; i++) begin
				evq_q[i] <= '0;
			end
		end else if (active && (e0v || e1v)) begin
			evq_q[tail] <= e0v ? e0 : e1;
			if (e0v && e1v) begin
				evq_q[tail + QPTR_W'(1)] <= e1;
			end
		end
	end

	assign in_ready  = cnt_q < QCNT_W'(QDEPTH - 1);
	assign out_valid = cnt_q != '0;

	assign event_kind        = evq_q[head_q].kind;
	assign channel           = evq_q[head_q].channel;
	assign row_delay         = evq_q[head_q].row_delay;
	assign instrument        = evq_q[head_q].instrument;
	assign note              = evq_q[head_q].note;
	assign level             = evq_q[head_q].level;
	assign use_default_level = evq_q[head_q].use_default_level;
	assign tempo_value       = evq_q[head_q].tempo_value;
	assign last              = evq_q[head_q].last;

endmodule
